@@ rtl/fwmp_pkg.sv @@
// shared types and constants of the weight mantissa packer
package fwmp_pkg;

  localparam int unsigned PositionWidthDefault = 32;

  localparam logic [1:0] ModeHalf   = 2'd0;
  localparam logic [1:0] ModeSingle = 2'd1;
  localparam logic [1:0] ModeDouble = 2'd2;
  localparam logic [1:0] ModeReset  = ModeSingle;

  localparam logic KindByte    = 1'b0;
  localparam logic KindOutlier = 1'b1;

  localparam logic [63:0] ThrHalf   = 64'h0000_0000_0000_3BFE;
  localparam logic [63:0] ThrSingle = 64'h0000_0000_3F7F_FFFE;
  localparam logic [63:0] ThrDouble = 64'h3FEF_FFFF_FFFE_A028;

  typedef struct packed {
    logic [63:0] weight_bits;
    logic        last_in_chunk;
  } in_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  packed_byte;
    logic [63:0] outlier_bits;
    logic [31:0] outlier_position;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic        kind;
    logic [52:0] code;
    logic [5:0]  nbits;
    logic [63:0] bits;
    logic [31:0] pos;
    logic        last;
  } entry_t;

endpackage

@@ rtl/fwmp_front.sv @@
// front end: classifies a weight, rounds 1+|w| and forms the code
module fwmp_front #(
  parameter int unsigned PositionWidth = fwmp_pkg::PositionWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        mode_i,
  input  fwmp_pkg::in_t     item_i,
  input  logic              accept_i,
  output fwmp_pkg::entry_t  entry_o
);
  import fwmp_pkg::*;

  logic [PositionWidth-1:0] pos_q, pos_d;
  logic [5:0]  mbits;
  logic [10:0] bias;
  logic [63:0] thr, w, mag, mmask, frac, sig, rem, half, q;
  logic [10:0] expo;
  logic [11:0] s;
  logic        sign;

  always_comb begin
    case (mode_i)
      ModeHalf: begin
        mbits = 6'd10; bias = 11'd15; thr = ThrHalf;
        w     = {48'b0, item_i.weight_bits[15:0]};
        mag   = {49'b0, w[14:0]};
        sign  = w[15];
      end
      ModeSingle: begin
        mbits = 6'd23; bias = 11'd127; thr = ThrSingle;
        w     = {32'b0, item_i.weight_bits[31:0]};
        mag   = {33'b0, w[30:0]};
        sign  = w[31];
      end
      default: begin
        mbits = 6'd52; bias = 11'd1023; thr = ThrDouble;
        w     = item_i.weight_bits;
        mag   = {1'b0, w[62:0]};
        sign  = w[63];
      end
    endcase
    mmask = (64'd1 << mbits) - 64'd1;
    frac  = mag & mmask;
    expo  = 11'(mag >> mbits);
    if (expo == 11'd0) begin
      sig  = frac;
      expo = 11'd1;
    end else begin
      sig = frac | (64'd1 << mbits);
    end
    s = {1'b0, bias} - {1'b0, expo};
    if (s >= {6'b0, mbits} + 12'd2) begin
      q    = 64'd0;
      rem  = 64'd0;
      half = 64'd0;
    end else begin
      rem  = sig & ((64'd1 << s[5:0]) - 64'd1);
      half = 64'd1 << (s[5:0] - 6'd1);
      q    = sig >> s[5:0];
      if (rem > half || (rem == half && q[0])) begin
        q = q + 64'd1;
      end
    end
  end

  always_comb begin
    entry_o.kind  = (mag < thr) ? KindByte : KindOutlier;
    entry_o.code  = 53'(((q & mmask) << 1) | {63'b0, sign && (mag != 64'd0)});
    entry_o.nbits = mbits + 6'd1;
    entry_o.bits  = w;
    entry_o.pos   = 32'(pos_q);
    entry_o.last  = item_i.last_in_chunk;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      pos_d = item_i.last_in_chunk ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/fwmp_fifo.sv @@
// two-entry queue between front and back
module fwmp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fwmp_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output fwmp_pkg::entry_t rdata_o
);
  import fwmp_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ rtl/fwmp_back.sv @@
// back end: bit packing into bytes, outlier records and chunk flush
module fwmp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  fwmp_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fwmp_pkg::out_t   out_data_o
);
  import fwmp_pkg::*;

  logic        act_q, outl_q, last_q, out_valid_q;
  logic [63:0] sr_q, sr_n, obits_q, bufal, codeal;
  logic [5:0]  cnt_q, cnt_n, cnt_l;
  logic [31:0] opos_q;
  logic [6:0]  buf_q;
  logic [2:0]  bcnt_q;
  logic        outl_n, out_free, emit, done;
  out_t        res, out_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = !act_q && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign bufal  = {buf_q, 57'b0} << (3'd7 - bcnt_q);
  assign codeal = {entry_i.code, 11'b0} << (6'd53 - entry_i.nbits);
  assign cnt_l  = {3'b0, bcnt_q} + ((entry_i.kind == KindByte) ? entry_i.nbits : 6'd0);

  always_comb begin
    sr_n   = sr_q;
    cnt_n  = cnt_q;
    outl_n = outl_q;
    emit   = 1'b0;
    res    = '0;
    if (outl_q) begin
      emit                 = 1'b1;
      res.record_kind      = KindOutlier;
      res.outlier_bits     = obits_q;
      res.outlier_position = opos_q;
      outl_n               = 1'b0;
    end else if (cnt_q >= 6'd8) begin
      emit            = 1'b1;
      res.record_kind = KindByte;
      res.packed_byte = sr_q[63:56];
      sr_n            = sr_q << 8;
      cnt_n           = cnt_q - 6'd8;
    end else if (last_q && cnt_q != 6'd0) begin
      emit            = 1'b1;
      res.record_kind = KindByte;
      res.packed_byte = sr_q[63:56];
      sr_n            = '0;
      cnt_n           = 6'd0;
    end
    done            = !outl_n && cnt_n < 6'd8 && !(last_q && cnt_n != 6'd0);
    res.last_of_run = done;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      obits_q <= entry_i.bits;
      opos_q  <= entry_i.pos;
    end
    if (out_free && emit && act_q) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      outl_q      <= 1'b0;
      last_q      <= 1'b0;
      sr_q        <= '0;
      cnt_q       <= '0;
      buf_q       <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= act_q && emit;
      end
      if (pop_o) begin
        act_q  <= 1'b1;
        outl_q <= entry_i.kind == KindOutlier;
        last_q <= entry_i.last;
        sr_q   <= (entry_i.kind == KindByte) ? (bufal | (codeal >> bcnt_q)) : bufal;
        cnt_q  <= cnt_l;
      end else if (act_q && (out_free || !emit)) begin
        sr_q   <= sr_n;
        cnt_q  <= cnt_n;
        outl_q <= outl_n;
        if (done) begin
          act_q  <= 1'b0;
          buf_q  <= sr_n[63:57] >> (3'd7 - cnt_n[2:0]);
          bcnt_q <= cnt_n[2:0];
        end
      end
    end
  end

endmodule

@@ rtl/float_weight_mantissa_packer.sv @@
// weight mantissa packer: items are queued, loaded into the back end, registered out
// throughput: one result per cycle unless stalled; a new item waits for the last
// a double weight yields up to 7 full bytes, or a record, and a flush at chunk end
// the back end emits one byte per cycle unless stalled and sets the item rate
// reset: asynchronous active low, clears position, bit buffer, queue; mode to single
module float_weight_mantissa_packer #(
  parameter int unsigned PositionWidth = fwmp_pkg::PositionWidthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fwmp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fwmp_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_data_i
);
  import fwmp_pkg::*;

  logic [1:0] mode_q;
  logic       accept, full, empty, pop;
  entry_t     wentry, rentry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  fwmp_front #(.PositionWidth(PositionWidth)) u_front (
    .clk_i, .rst_ni, .mode_i(mode_q), .item_i(in_data_i), .accept_i(accept),
    .entry_o(wentry)
  );

  fwmp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(accept), .wdata_i(wentry), .full_o(full),
    .pop_i(pop), .empty_o(empty), .rdata_o(rentry)
  );

  fwmp_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(rentry), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef ASSERT_OFF
  a_outlier_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind == KindOutlier |-> out_data_o.packed_byte == 8'd0)
    else $error("outlier record carries a byte");
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind == KindByte |->
      out_data_o.outlier_bits == 64'd0 && out_data_o.outlier_position == 32'd0)
    else $error("byte record carries outlier fields");
`endif

endmodule
